FILE: rtl/fps_pkg.sv
// Shared types, constants and helpers for the fast packet segmenter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package fps_pkg;

  localparam int FPS_TABLE_ENTRIES = 256;
  localparam int QUEUE_DEPTH       = 4;

  localparam int ID_W   = 29;
  localparam int LEN_W  = 8;
  localparam int BYTE_W = 8;
  localparam int PGN_W  = 17;
  localparam int SEQ_W  = 3;
  localparam int POS_W  = 3;
  localparam int FIDX_W = 5;
  localparam int FLEN_W = 4;
  localparam int DATA_W = 64;

  localparam logic [7:0]        PF_PDU2_MIN   = 8'd240;
  localparam logic [BYTE_W-1:0] PAD_BYTE      = 8'hFF;
  localparam logic [POS_W-1:0]  POS_FAST_HEAD = 3'd2;
  localparam logic [POS_W-1:0]  POS_LAST      = 3'd7;
  localparam logic [FLEN_W-1:0] FLEN_FULL     = 4'd8;

  typedef enum logic [1:0] {
    SRCH_IDLE,
    SRCH_LOOK,
    SRCH_CMP,
    SRCH_DONE
  } srch_state_t;

  // One classified payload byte as passed from front to back.
  typedef struct packed {
    logic [ID_W-1:0]   can_id;
    logic [LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0] data_byte;
    logic              fast;
    logic              is_start;
    logic [POS_W-1:0]  pos;
    logic              closes;
    logic              lastf;
    logic [SEQ_W-1:0]  seq;
  } fps_item_t;

  // PGN from an extended id; PDU1 formats carry no group extension.
  function automatic logic [PGN_W-1:0] pgn_of(input logic [ID_W-1:0] id);
    logic [PGN_W-1:0] pgn;
    pgn = id[24:8];
    if (pgn[15:8] < PF_PDU2_MIN) begin
      pgn[7:0] = 8'd0;
    end
    return pgn;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fast_packet_segmenter_unit.sv
// Fast packet segmenter: turns a byte stream of CAN messages into frames.
// Built from fps_front, fps_queue and fps_back; depends on fps_pkg.
//
// Input channel (in_*): one payload byte per transaction with the message's
// CAN id, length and mode; in_last_byte marks the final byte. Output channel
// (out_*): one CAN frame per transaction, 8 bytes in fast mode, up to 8 in
// single mode, out_last_frame on the final frame of a message.
// Throughput: one byte per cycle while the queue has room, except the first
// byte of a fast message, which holds the front for the PGN table search:
// the search reads the occupied entries one at a time through the single
// read port of the table memory, each in a look state and a compare state,
// and ends on a hit or after the last occupied entry.
// Path: a closing byte passes through the hold register, then a queue
// slot, which pops into the output register.
// Receiver stall: the output register holds its frame; the back keeps
// building the next frame until that one closes, then the queue fills and
// in_stall rises. Reset: position tracking, queue and output clear at once;
// the PGN table empties by clearing its fill count, so no sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
module fast_packet_segmenter_unit #(
  parameter int TABLE_ENTRIES = fps_pkg::FPS_TABLE_ENTRIES
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [fps_pkg::ID_W-1:0]    in_can_id,
  input  wire  [fps_pkg::LEN_W-1:0]   in_msg_len,
  input  wire  [fps_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire                         in_last_byte,
  input  wire                         in_fast_mode,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [fps_pkg::ID_W-1:0]    out_can_id,
  output logic [fps_pkg::DATA_W-1:0]  out_frame_data,
  output logic [fps_pkg::FLEN_W-1:0]  out_frame_len,
  output logic                        out_last_frame
);
  import fps_pkg::*;

  // Classified items flow front -> queue -> back.
  fps_item_t push_item, head_item;
  logic      q_push, q_full, q_pop, q_valid;

  // Classify bytes and fetch the sequence count at the start of a fast message.
  fps_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_can_id    (in_can_id),
    .in_msg_len   (in_msg_len),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_fast_mode (in_fast_mode),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // Decouple the search stalls from output back-pressure.
  fps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (head_item)
  );

  // Assemble frames and present them on the output register.
  fps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (head_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_can_id     (out_can_id),
    .out_frame_data (out_frame_data),
    .out_frame_len  (out_frame_len),
    .out_last_frame (out_last_frame)
  );

endmodule
`default_nettype wire

FILE: rtl/fps_queue.sv
// Short flip-flop queue of classified items between front and back.
// Depends on fps_pkg for the item type and the depth.
`timescale 1ns / 1ps
`default_nettype none
module fps_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  fps_pkg::fps_item_t  push_item,
  output logic                full,
  input  wire                 pop,
  output logic                q_valid,
  output fps_pkg::fps_item_t  q_item
);
  import fps_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fps_item_t        slot_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fps_front.sv
// Front end: accepts payload bytes, tracks message position and looks up
// the per-PGN sequence count in the PGN table. Depends on fps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fps_front #(
  parameter int TABLE_ENTRIES = fps_pkg::FPS_TABLE_ENTRIES
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [fps_pkg::ID_W-1:0]   in_can_id,
  input  wire  [fps_pkg::LEN_W-1:0]  in_msg_len,
  input  wire  [fps_pkg::BYTE_W-1:0] in_data_byte,
  input  wire                        in_last_byte,
  input  wire                        in_fast_mode,
  input  wire                        q_full,
  output logic                       q_push,
  output fps_pkg::fps_item_t         q_item
);
  import fps_pkg::*;

  localparam int FW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW = PGN_W + SEQ_W;

  logic [EW-1:0]    tbl [TABLE_ENTRIES];
  logic [EW-1:0]    rd_r;

  srch_state_t      state_r, state_nxt;
  logic [FW-1:0]    idx_r, fill_r;
  logic [PGN_W-1:0] pgn_r;
  fps_item_t        hold_r;
  logic             hold_v_r, hold_srch_r;
  logic             in_msg_r;
  logic [POS_W-1:0] pos_r;

  logic             accept, start_srch, hold_ready;
  logic [POS_W-1:0] pos0;
  logic             closes, lastf;
  logic             at_end, key_hit;

  logic             wr_en, seq_set, fill_inc, idx_inc;
  logic [FW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;
  logic [SEQ_W-1:0] seq_val;

  // Classify the incoming byte against the running message position.
  assign pos0   = in_msg_r ? pos_r : (in_fast_mode ? POS_FAST_HEAD : '0);
  assign closes = (pos0 == POS_LAST) || in_last_byte;
  assign lastf  = closes && (in_last_byte || !in_fast_mode);

  assign hold_ready = !hold_srch_r || (state_r == SRCH_DONE);
  assign q_push     = hold_v_r && hold_ready && !q_full;
  assign in_stall   = hold_v_r && !q_push;
  assign accept     = in_valid && !in_stall;
  assign start_srch = accept && !in_msg_r && in_fast_mode;
  assign q_item     = hold_r;

  assign at_end  = (idx_r == fill_r);
  assign key_hit = (rd_r[EW-1:SEQ_W] == pgn_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SRCH_IDLE: if (start_srch) state_nxt = SRCH_LOOK;
      SRCH_LOOK: state_nxt = at_end ? SRCH_DONE : SRCH_CMP;
      SRCH_CMP:  state_nxt = key_hit ? SRCH_DONE : SRCH_LOOK;
      SRCH_DONE: begin
        if (start_srch) begin
          state_nxt = SRCH_LOOK;
        end else if (q_push) begin
          state_nxt = SRCH_IDLE;
        end
      end
      default:   state_nxt = SRCH_IDLE;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = {pgn_r, rd_r[SEQ_W-1:0] + 1'b1};
    seq_set  = 1'b0;
    seq_val  = '0;
    fill_inc = 1'b0;
    idx_inc  = 1'b0;
    case (state_r)
      SRCH_LOOK: begin
        if (at_end) begin
          // Miss: insert with count zero unless full or the PGN is zero.
          seq_set = 1'b1;
          if ((fill_r != FW'(TABLE_ENTRIES)) && (pgn_r != '0)) begin
            wr_en    = 1'b1;
            wr_addr  = fill_r;
            wr_data  = {pgn_r, {SEQ_W{1'b0}}};
            fill_inc = 1'b1;
          end
        end
      end
      SRCH_CMP: begin
        if (key_hit) begin
          wr_en   = 1'b1;
          seq_set = 1'b1;
          seq_val = rd_r[SEQ_W-1:0] + 1'b1;
        end else begin
          idx_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr[IW-1:0]] <= wr_data;
    end
    if (state_r == SRCH_LOOK) begin
      rd_r <= tbl[idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (start_srch) begin
      pgn_r <= pgn_of(in_can_id);
    end
    if (accept) begin
      hold_r.can_id    <= in_can_id;
      hold_r.msg_len   <= in_msg_len;
      hold_r.data_byte <= in_data_byte;
      hold_r.fast      <= in_fast_mode;
      hold_r.is_start  <= !in_msg_r;
      hold_r.pos       <= pos0;
      hold_r.closes    <= closes;
      hold_r.lastf     <= lastf;
      hold_r.seq       <= '0;
    end else if (seq_set) begin
      hold_r.seq       <= seq_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SRCH_IDLE;
      idx_r       <= '0;
      fill_r      <= '0;
      hold_v_r    <= 1'b0;
      hold_srch_r <= 1'b0;
      in_msg_r    <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_srch) begin
        idx_r <= '0;
      end else if (idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (fill_inc) begin
        fill_r <= fill_r + 1'b1;
      end
      if (accept) begin
        hold_v_r    <= 1'b1;
        hold_srch_r <= start_srch;
        if (lastf) begin
          in_msg_r <= 1'b0;
          pos_r    <= '0;
        end else begin
          in_msg_r <= 1'b1;
          pos_r    <= closes ? POS_W'(1) : pos0 + 1'b1;
        end
      end else if (q_push) begin
        hold_v_r    <= 1'b0;
        hold_srch_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fps_back.sv
// Back end: assembles frame bytes from queued items and holds the
// finished frame in the output register. Depends on fps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fps_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         q_valid,
  input  fps_pkg::fps_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [fps_pkg::ID_W-1:0]    out_can_id,
  output logic [fps_pkg::DATA_W-1:0]  out_frame_data,
  output logic [fps_pkg::FLEN_W-1:0]  out_frame_len,
  output logic                        out_last_frame
);
  import fps_pkg::*;

  logic [DATA_W-1:0] buf_r, buf_nxt;
  logic [FIDX_W-1:0] fidx_r, fidx_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic              out_valid_r;

  logic [DATA_W-1:0] base, asm_data, pad_data;
  logic [FIDX_W-1:0] fidx_base;
  logic              head_fast;

  assign q_pop     = q_valid && !(q_item.closes && out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign head_fast = q_item.is_start && q_item.fast;

  always_comb begin
    if (!q_item.is_start) begin
      base = buf_r;
    end else if (q_item.fast) begin
      base = {{(DATA_W-16){1'b0}}, q_item.msg_len, q_item.seq, {FIDX_W{1'b0}}};
    end else begin
      base = '0;
    end
    seq_nxt   = head_fast ? q_item.seq : seq_r;
    fidx_base = q_item.is_start ? '0 : fidx_r;

    // Drop the byte into place; pad the tail of a closing fast frame.
    for (int k = 0; k < 8; k++) begin
      if (q_item.pos == POS_W'(k)) begin
        asm_data[8*k +: 8] = q_item.data_byte;
        pad_data[8*k +: 8] = q_item.data_byte;
      end else begin
        asm_data[8*k +: 8] = base[8*k +: 8];
        if (q_item.fast && (POS_W'(k) > q_item.pos)) begin
          pad_data[8*k +: 8] = PAD_BYTE;
        end else begin
          pad_data[8*k +: 8] = base[8*k +: 8];
        end
      end
    end

    fidx_nxt = fidx_base;
    buf_nxt  = asm_data;
    if (q_item.closes && !q_item.lastf) begin
      fidx_nxt = fidx_base + 1'b1;
      buf_nxt  = {{(DATA_W-8){1'b0}}, seq_nxt, fidx_base + 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.closes) begin
      out_can_id     <= q_item.can_id;
      out_frame_data <= pad_data;
      out_frame_len  <= q_item.fast ? FLEN_FULL : {1'b0, q_item.pos} + 1'b1;
      out_last_frame <= q_item.lastf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      fidx_r      <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        buf_r  <= buf_nxt;
        fidx_r <= fidx_nxt;
        seq_r  <= seq_nxt;
      end
      if (q_pop && q_item.closes) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for fast_packet_segmenter_unit: directed table, then random messages.
// Needs fps_pkg and the segmenter RTL; the frame predictor lives in this file.
`timescale 1ns / 1ps
module tb;
  import fps_pkg::*;

  localparam int LONG_HOLD = 600;   // receiver hold-off, in cycles, for the fill-up test
  localparam int DIR_ROWS  = 24;

  // One payload byte as offered on the input channel. The pin_* fields carry a
  // hand-written expectation for directed rows; otherwise the predictor decides.
  typedef struct packed {
    logic [ID_W-1:0]   can_id;
    logic [LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              fast_mode;
    logic              pinned;
    logic              pin_out;
    logic [DATA_W-1:0] pin_data;
    logic [FLEN_W-1:0] pin_len;
    logic              pin_last;
  } byte_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   can_id;
    logic [DATA_W-1:0] data;
    logic [FLEN_W-1:0] frame_len;
    logic              is_last;
  } frame_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ID_W-1:0]     in_can_id = '0;
  logic [LEN_W-1:0]    in_msg_len = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                in_last_byte = 1'b0;
  logic                in_fast_mode = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ID_W-1:0]     out_can_id;
  logic [DATA_W-1:0]   out_frame_data;
  logic [FLEN_W-1:0]   out_frame_len;
  logic                out_last_frame;

  // Bytes waiting to be offered, and frames waiting to come out.
  byte_item_t stim_q[$];
  frame_t     frame_exp_q[$];
  byte_item_t offer;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int err_count    = 0;
  bit hold_req     = 1'b0;
  bit hold_seen    = 1'b0;
  int hold_left    = 0;

  // Predictor state: PGN sequence table and the frame under construction.
  logic [PGN_W-1:0]  pgn_key [FPS_TABLE_ENTRIES];
  logic [SEQ_W-1:0]  pgn_cnt [FPS_TABLE_ENTRIES];
  logic [DATA_W-1:0] seg_buf;
  logic [POS_W-1:0]  seg_pos;
  logic [FIDX_W-1:0] seg_fidx;
  logic [SEQ_W-1:0]  seg_seq;
  bit                seg_busy;

  always #4 clk = ~clk;

  fast_packet_segmenter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_can_id      (in_can_id),
    .in_msg_len     (in_msg_len),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_fast_mode   (in_fast_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_can_id     (out_can_id),
    .out_frame_data (out_frame_data),
    .out_frame_len  (out_frame_len),
    .out_last_frame (out_last_frame)
  );

  // PGN of an extended id; PDU1 formats (PF below 240) drop the PS byte.
  function automatic logic [PGN_W-1:0] group_of(input logic [ID_W-1:0] id);
    logic [PGN_W-1:0] g;
    g = id[24:8];
    if (g[15:8] < PF_PDU2_MIN) begin
      g[7:0] = 8'd0;
    end
    return g;
  endfunction

  // Linear table search: first empty slot takes the PGN with count 0, a hit
  // advances its count modulo 8, and a full table yields 0 without inserting.
  function automatic logic [SEQ_W-1:0] next_seq(input logic [PGN_W-1:0] g);
    int i;
    for (i = 0; i < FPS_TABLE_ENTRIES; i++) begin
      if (pgn_key[i] == '0) begin
        pgn_key[i] = g;
        pgn_cnt[i] = '0;
        return '0;
      end
      if (pgn_key[i] == g) begin
        pgn_cnt[i] = pgn_cnt[i] + 1'b1;
        return pgn_cnt[i];
      end
    end
    return '0;
  endfunction

  // Advance the predictor by one accepted byte; made is set when it closes a frame.
  task automatic seg_predict(input byte_item_t it, output bit made, output frame_t fr);
    logic [POS_W-1:0] pos;
    int               k;
    bit               closes_msg;
    made = 1'b0;
    fr   = '0;
    if (!seg_busy) begin
      seg_busy = 1'b1;
      seg_fidx = '0;
      if (it.fast_mode) begin
        seg_seq = next_seq(group_of(it.can_id));
        seg_buf = {48'd0, it.msg_len, seg_seq, 5'd0};
        seg_pos = POS_FAST_HEAD;
      end else begin
        seg_buf = '0;
        seg_pos = '0;
      end
    end
    pos = seg_pos;
    seg_buf[8*pos +: 8] = it.data_byte;
    if (pos != POS_LAST && !it.last_byte) begin
      seg_pos = pos + 1'b1;
    end else begin
      if (it.fast_mode) begin
        for (k = int'(pos) + 1; k < 8; k++) begin
          seg_buf[8*k +: 8] = PAD_BYTE;
        end
        fr.frame_len = FLEN_FULL;
      end else begin
        fr.frame_len = {1'b0, pos} + 1'b1;
      end
      closes_msg  = it.last_byte || !it.fast_mode;
      fr.can_id   = it.can_id;
      fr.data     = seg_buf;
      fr.is_last  = closes_msg;
      made        = 1'b1;
      if (closes_msg) begin
        seg_busy = 1'b0;
        seg_pos  = '0;
      end else begin
        // continuation frame: index and sequence in byte 0, data from byte 1
        seg_fidx = seg_fidx + 1'b1;
        seg_buf  = {56'd0, seg_seq, seg_fidx};
        seg_pos  = 3'd1;
      end
    end
  endtask

  function automatic byte_item_t dir_row(
    input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] b,
    input bit lst, input bit fst, input bit pin, input bit pout,
    input logic [DATA_W-1:0] pdata, input logic [FLEN_W-1:0] plen, input bit plast);
    byte_item_t r;
    r = '{can_id: id, msg_len: len, data_byte: b, last_byte: lst, fast_mode: fst,
          pinned: pin, pin_out: pout, pin_data: pdata, pin_len: plen, pin_last: plast};
    return r;
  endfunction

  // Mostly ids from a small pool of PGNs, so sequence counts climb and wrap;
  // now and then a fully random id.
  function automatic logic [ID_W-1:0] pick_id();
    logic [PGN_W-1:0] g;
    logic [ID_W-1:0]  id;
    if ($urandom_range(0, 9) == 0) begin
      return ID_W'($urandom);
    end
    case ($urandom_range(0, 5))
      0: g = 17'h1F801;
      1: g = 17'h1F802;
      2: g = 17'h1FD02;
      3: g = 17'h0EA00;
      4: g = 17'h1EF00;
      default: g = 17'h1F010;
    endcase
    id = {3'($urandom), 1'($urandom), g, 8'($urandom)};
    if (g[15:8] < PF_PDU2_MIN) begin
      id[15:8] = 8'($urandom);
    end
    return id;
  endfunction

  // Queue one message of n bytes; mess scatters mode flips and id changes.
  task automatic queue_message(input logic [ID_W-1:0] id, input int n,
                               input logic [LEN_W-1:0] lenf, input bit fast, input bit mess);
    byte_item_t it;
    int         j;
    for (j = 0; j < n; j++) begin
      it           = '0;
      it.can_id    = (mess && $urandom_range(0, 15) == 0) ? pick_id() : id;
      it.msg_len   = lenf;
      it.data_byte = 8'($urandom);
      it.last_byte = (j == n - 1);
      it.fast_mode = (mess && $urandom_range(0, 15) == 0) ? !fast : fast;
      stim_q.push_back(it);
    end
  endtask

  task automatic queue_random_message(output int n);
    int               kind;
    logic [LEN_W-1:0] lenf;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // well-formed fast message, now and then a long one
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 223) : $urandom_range(1, 20);
      queue_message(pick_id(), n, LEN_W'(n), 1'b1, 1'b0);
    end else if (kind < 80) begin
      n = $urandom_range(1, 8);
      queue_message(pick_id(), n, LEN_W'(n), 1'b0, 1'b0);
    end else if (kind < 92) begin
      // length byte that disagrees with the byte count, plus noise
      n    = $urandom_range(1, 40);
      lenf = LEN_W'($urandom_range(1, 223));
      queue_message(pick_id(), n, lenf, 1'b1, 1'b1);
    end else begin
      // single mode, up to 20 bytes and so often past 8, plus noise
      n = $urandom_range(1, 20);
      queue_message(pick_id(), n, LEN_W'(n), 1'b0, 1'b1);
    end
  endtask

  // Hold the main sequence until every byte is in and every frame is out.
  task automatic wait_drained();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || frame_exp_q.size() != 0);
  endtask

  task automatic run_random(input int tx_pct, input int rx_pct, input int count);
    int queued;
    int n;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    queued       = 0;
    while (queued < count) begin
      queue_random_message(n);
      queued += n;
    end
    wait_drained();
  endtask

  // Input side: predict on each accepted transaction, then offer the next byte.
  always @(posedge clk) begin : drive_in
    bit     made;
    frame_t fr;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seg_predict(offer, made, fr);
        if (offer.pinned) begin
          if (offer.pin_out) begin
            fr = '{can_id: offer.can_id, data: offer.pin_data,
                   frame_len: offer.pin_len, is_last: offer.pin_last};
            frame_exp_q.push_back(fr);
          end
        end else if (made) begin
          frame_exp_q.push_back(fr);
        end
      end
      // a stalled transaction holds its payload; otherwise advance or idle
      if (!(in_valid && in_stall)) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          offer        = stim_q.pop_front();
          in_valid     <= 1'b1;
          in_can_id    <= offer.can_id;
          in_msg_len   <= offer.msg_len;
          in_data_byte <= offer.data_byte;
          in_last_byte <= offer.last_byte;
          in_fast_mode <= offer.fast_mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each accepted frame with the oldest expectation, and
  // drive the stall, including the long hold-off counted here.
  always @(posedge clk) begin : take_out
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_exp_q.size() == 0) begin
        $display("%0t: frame with none expected: id %h data %h len %0d last %b",
                 $time, out_can_id, out_frame_data, out_frame_len, out_last_frame);
        err_count++;
      end else begin
        want = frame_exp_q.pop_front();
        if (out_can_id !== want.can_id) begin
          $display("%0t: out_can_id expected %h actual %h", $time, want.can_id, out_can_id);
          err_count++;
        end
        if (out_frame_data !== want.data) begin
          $display("%0t: out_frame_data expected %h actual %h",
                   $time, want.data, out_frame_data);
          err_count++;
        end
        if (out_frame_len !== want.frame_len) begin
          $display("%0t: out_frame_len expected %0d actual %0d",
                   $time, want.frame_len, out_frame_len);
          err_count++;
        end
        if (out_last_frame !== want.is_last) begin
          $display("%0t: out_last_frame expected %b actual %b",
                   $time, want.is_last, out_last_frame);
          err_count++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  initial begin : main_seq
    int              i;
    int              n;
    byte_item_t      dir_tab [DIR_ROWS];
    logic [ID_W-1:0] id;
    for (i = 0; i < FPS_TABLE_ENTRIES; i++) begin
      pgn_key[i] = '0;
      pgn_cnt[i] = '0;
    end
    seg_buf  = '0;
    seg_pos  = '0;
    seg_fidx = '0;
    seg_seq  = '0;
    seg_busy = 1'b0;
    offer    = '0;

    // Directed rows. Single byte in single mode, all-ones id.
    dir_tab[0] = dir_row(29'h1FFFFFFF, 8'd1, 8'hA5, 1, 0, 1, 1, 64'h00000000000000A5, 4'd1, 1);
    // New PDU2 PGN: count 0, then the same PGN again gives count 1; length extremes.
    dir_tab[1] = dir_row(29'h09F80100, 8'd1, 8'h00, 1, 1, 1, 1, 64'hFFFFFFFFFF000100, 4'd8, 1);
    dir_tab[2] = dir_row(29'h09F80100, 8'hDF, 8'hFF, 1, 1, 1, 1, 64'hFFFFFFFFFFFFDF20, 4'd8, 1);
    // PGN zero takes an empty slot that stays empty, so its count stays 0.
    dir_tab[3] = dir_row(29'h00000000, 8'd2, 8'h12, 0, 1, 1, 0, '0, '0, 0);
    dir_tab[4] = dir_row(29'h00000000, 8'd2, 8'h34, 1, 1, 1, 1, 64'hFFFFFFFF34120200, 4'd8, 1);
    dir_tab[5] = dir_row(29'h00000055, 8'd1, 8'h56, 1, 1, 1, 1, 64'hFFFFFFFFFF560100, 4'd8, 1);
    // PDU1: PS byte differs but the PGN is the same, so the count advances.
    dir_tab[6] = dir_row(29'h18EA0512, 8'd1, 8'h01, 1, 1, 1, 1, 64'hFFFFFFFFFF010100, 4'd8, 1);
    dir_tab[7] = dir_row(29'h18EA0634, 8'd1, 8'h02, 1, 1, 1, 1, 64'hFFFFFFFFFF020120, 4'd8, 1);
    // Fast message of 7 bytes: full first frame, then a padded continuation.
    for (i = 0; i < 7; i++) begin
      dir_tab[8+i] = dir_row(29'h0DF01023, 8'd7, 8'(8'h11 + i), i == 6, 1, 0, 0, '0, '0, 0);
    end
    // Single mode with 9 bytes: the 8th closes the frame, the 9th starts anew.
    for (i = 0; i < 9; i++) begin
      dir_tab[15+i] = dir_row(29'h00ABCDEF, 8'd9, 8'(8'h80 + i), i == 8, 0, 0, 0, '0, '0, 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (i = 0; i < DIR_ROWS; i++) begin
      stim_q.push_back(dir_tab[i]);
    end
    wait_drained();

    run_random(0, 0, 60);
    run_random(63, 0, 70);
    run_random(0, 63, 70);
    run_random(18, 18, 70);

    // Fill-up: the receiver holds off while a long fast message streams in,
    // long enough for the frame index to wrap past 31.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = ~hold_req;
    queue_message(pick_id(), 240, 8'd223, 1'b1, 1'b0);
    for (i = 0; i < 4; i++) begin
      queue_random_message(n);
    end
    wait_drained();

    // Fill the PGN table with distinct PDU2 groups until it runs out of slots.
    tx_idle_pct  = 18;
    rx_stall_pct = 18;
    for (i = 0; i < 260; i++) begin
      id = {3'd3, 1'b0, 1'b1, 8'(240 + i / 256), 8'(i % 256), 8'($urandom)};
      queue_message(id, 1, 8'd1, 1'b1, 1'b0);
    end
    wait_drained();

    // Full table: fresh PGNs get count 0, known ones still advance.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (i = 0; i < 5; i++) begin
      id = {3'($urandom), 1'b0, 1'b1, 8'hFA, 8'($urandom), 8'($urandom)};
      queue_message(id, $urandom_range(1, 14), 8'd14, 1'b1, 1'b0);
    end
    run_random(18, 18, 40);

    // let any trailing frame surface before the verdict
    repeat (16) @(posedge clk);
    if (err_count == 0 && frame_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a correct run ends well inside this, even with full-table searches.
  initial begin : watchdog
    #24_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
